// File: sv/dpfl_pkg.sv
// Shared types, constants and helpers for the dual-pool free-list allocator.
package dpfl_pkg;

  localparam int POOL_DEPTH = 1024;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 13;
  localparam int COUNT_W = 11;
  localparam int FREE_W  = 11;
  localparam int IDX_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LVL_W   = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W   = (LVL_W > COUNT_W) ? LVL_W : COUNT_W;
  localparam int SPAN_W  = SIZE_W + LVL_W;
  localparam int SH_W    = SIZE_W + IDX_W;
  localparam int DCNT_W  = $clog2(IDX_W + 1);
  localparam int START_W = ADDR_W + 1;
  localparam int END_W   = ADDR_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT_B = 3'd4;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_NULL  = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETTLE0,
    S_SETTLE1,
    S_DECODE,
    S_ALLOC_MUL,
    S_ALLOC_ADD,
    S_DIV,
    S_PUSH,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    pop;
    logic    mul;
    logic    div_start;
    logic    div_step;
    logic    push;
    logic    clr_start;
    logic    clr_step;
    logic    clr_finish;
    logic    load_result;
    logic    use_alloc_addr;
    status_t res_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       null_addr;
    logic       out_of_range;
    logic       full;
    logic       empty;
    logic       div_done;
    logic       clr_done;
  } dp_stat_t;

  // Stack level as seen on the free_blocks field (low eleven bits).
  function automatic logic [FREE_W-1:0] free_field(input logic [LVL_W-1:0] lvl);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(lvl);
    return wide[FREE_W-1:0];
  endfunction

endpackage

// File: sv/dual_pool_free_list_allocator_top.sv
// Top level of the dual-pool free-list block allocator.
//
//  channel   | direction | handshake           | contents
//  ----------+-----------+---------------------+-------------------------------------
//  s_*       | in        | s_tvalid / s_tready | tuser: action, pool; tdata: address
//  m_*       | out       | m_tvalid / m_tready | tuser: which_pool, status;
//            |           |                     | tdata: block_address, free_blocks
//  cfg_*     | in        | cfg_we              | cfg_index selects register, cfg_data
//
// One word is in flight at a time. An allocate passes through the multiply and add
// states; a free runs the restoring divider, one quotient bit per cycle, before the
// push; a clear writes one stack entry per cycle over the pool's block count. Other
// cases go from decode straight to the result. A stalled result holds until taken,
// then the block returns to idle. Reset is synchronous; the stacks need no
// clearing pass, since only entries below the stack level are ever read.
module dual_pool_free_list_allocator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [dpfl_pkg::IN_TDATA_W-1:0]      s_tdata,   // [31:0] address
  input  logic [dpfl_pkg::IN_TUSER_W-1:0]      s_tuser,   // [1:0] action, [2] pool
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dpfl_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [31:0] block_address,
                                                          // [42:32] free_blocks, zero pad
  output logic [dpfl_pkg::OUT_TUSER_W-1:0]     m_tuser,   // [0] which_pool, [3:1] status
  input  logic                                 cfg_we,
  input  logic [dpfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpfl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dpfl_pkg::ctrl_cmd_t cmd;
  dpfl_pkg::dp_stat_t  stat;

  logic [dpfl_pkg::ADDR_W-1:0] block_address;
  logic                        which_pool;
  logic [2:0]                  status;
  logic [dpfl_pkg::FREE_W-1:0] free_blocks;

  dpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dpfl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_action     (s_tuser[1:0]),
    .in_pool       (s_tuser[2]),
    .in_address    (s_tdata[dpfl_pkg::ADDR_W-1:0]),
    .cmd           (cmd),
    .stat          (stat),
    .block_address (block_address),
    .which_pool    (which_pool),
    .status        (status),
    .free_blocks   (free_blocks)
  );

  assign m_tdata = dpfl_pkg::OUT_TDATA_W'({free_blocks, block_address});
  assign m_tuser = {status, which_pool};

endmodule

// File: sv/dpfl_ctrl.sv
// Control state machine of the allocator: sequences decode, allocate, divide, push and refill.
module dpfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  dpfl_pkg::dp_stat_t   stat,
  output dpfl_pkg::ctrl_cmd_t  cmd
);

  dpfl_pkg::state_t state;
  dpfl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = dpfl_pkg::ST_OK;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      dpfl_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = dpfl_pkg::S_SETTLE0;
        end
      end
      // The settle states let the pool bounds catch up with a register write.
      dpfl_pkg::S_SETTLE0: state_next = dpfl_pkg::S_SETTLE1;
      dpfl_pkg::S_SETTLE1: state_next = dpfl_pkg::S_DECODE;
      dpfl_pkg::S_DECODE: begin
        case (stat.action)
          dpfl_pkg::OP_ALLOC: begin
            if (stat.empty) begin
              cmd.load_result = 1'b1;
              cmd.res_status  = dpfl_pkg::ST_EMPTY;
              state_next      = dpfl_pkg::S_DONE;
            end else begin
              cmd.pop    = 1'b1;
              state_next = dpfl_pkg::S_ALLOC_MUL;
            end
          end
          dpfl_pkg::OP_FREE: begin
            if (stat.null_addr) begin
              cmd.load_result = 1'b1;
              cmd.res_status  = dpfl_pkg::ST_NULL;
              state_next      = dpfl_pkg::S_DONE;
            end else if (stat.out_of_range) begin
              cmd.load_result = 1'b1;
              cmd.res_status  = dpfl_pkg::ST_RANGE;
              state_next      = dpfl_pkg::S_DONE;
            end else if (stat.full) begin
              cmd.load_result = 1'b1;
              cmd.res_status  = dpfl_pkg::ST_FULL;
              state_next      = dpfl_pkg::S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = dpfl_pkg::S_DIV;
            end
          end
          dpfl_pkg::OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = dpfl_pkg::S_CLEAR;
          end
          default: begin
            cmd.load_result = 1'b1;
            state_next      = dpfl_pkg::S_DONE;
          end
        endcase
      end
      dpfl_pkg::S_ALLOC_MUL: begin
        cmd.mul    = 1'b1;
        state_next = dpfl_pkg::S_ALLOC_ADD;
      end
      dpfl_pkg::S_ALLOC_ADD: begin
        cmd.load_result    = 1'b1;
        cmd.use_alloc_addr = 1'b1;
        state_next         = dpfl_pkg::S_DONE;
      end
      dpfl_pkg::S_DIV: begin
        if (stat.div_done) begin
          state_next = dpfl_pkg::S_PUSH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      dpfl_pkg::S_PUSH: begin
        cmd.push        = 1'b1;
        cmd.load_result = 1'b1;
        state_next      = dpfl_pkg::S_DONE;
      end
      dpfl_pkg::S_CLEAR: begin
        if (stat.clr_done) begin
          cmd.clr_finish  = 1'b1;
          cmd.load_result = 1'b1;
          state_next      = dpfl_pkg::S_DONE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      dpfl_pkg::S_DONE: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = dpfl_pkg::S_IDLE;
        end
      end
      default: state_next = dpfl_pkg::S_IDLE;
    endcase
  end

endmodule

// File: sv/dpfl_dp.sv
// Datapath of the allocator: registers, pool bounds, free stacks, divider and result.
module dpfl_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [dpfl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dpfl_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [1:0]                             in_action,
  input  logic                                   in_pool,
  input  logic [dpfl_pkg::ADDR_W-1:0]            in_address,
  input  dpfl_pkg::ctrl_cmd_t                    cmd,
  output dpfl_pkg::dp_stat_t                     stat,
  output logic [dpfl_pkg::ADDR_W-1:0]            block_address,
  output logic                                   which_pool,
  output logic [2:0]                             status,
  output logic [dpfl_pkg::FREE_W-1:0]            free_blocks
);

  localparam int IDX_W   = dpfl_pkg::IDX_W;
  localparam int LVL_W   = dpfl_pkg::LVL_W;
  localparam int CMP_W   = dpfl_pkg::CMP_W;
  localparam int SIZE_W  = dpfl_pkg::SIZE_W;
  localparam int SPAN_W  = dpfl_pkg::SPAN_W;
  localparam int SH_W    = dpfl_pkg::SH_W;
  localparam int DCNT_W  = dpfl_pkg::DCNT_W;
  localparam int START_W = dpfl_pkg::START_W;
  localparam int END_W   = dpfl_pkg::END_W;
  localparam int ADDR_W  = dpfl_pkg::ADDR_W;
  localparam int COUNT_W = dpfl_pkg::COUNT_W;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_size_a;
  logic [COUNT_W-1:0] block_count_a;
  logic [SIZE_W-1:0]  block_size_b;
  logic [COUNT_W-1:0] block_count_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= ADDR_W'(4096);
      block_size_a  <= SIZE_W'(64);
      block_count_a <= COUNT_W'(1024);
      block_size_b  <= SIZE_W'(64);
      block_count_b <= COUNT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        dpfl_pkg::CFG_BASE_ADDRESS:  base_address  <= cfg_data;
        dpfl_pkg::CFG_BLOCK_SIZE_A:  block_size_a  <= cfg_data[SIZE_W-1:0];
        dpfl_pkg::CFG_BLOCK_COUNT_A: block_count_a <= cfg_data[COUNT_W-1:0];
        dpfl_pkg::CFG_BLOCK_SIZE_B:  block_size_b  <= cfg_data[SIZE_W-1:0];
        dpfl_pkg::CFG_BLOCK_COUNT_B: block_count_b <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero block size counts as one byte; counts are capped at the stack depth.
  logic [SIZE_W-1:0] size_a_eff, size_b_eff;
  logic [CMP_W-1:0]  cnt_a_wide, cnt_b_wide;
  logic [LVL_W-1:0]  count_a_eff, count_b_eff;

  always_comb begin
    size_a_eff  = (block_size_a == '0) ? SIZE_W'(1) : block_size_a;
    size_b_eff  = (block_size_b == '0) ? SIZE_W'(1) : block_size_b;
    cnt_a_wide  = CMP_W'(block_count_a);
    cnt_b_wide  = CMP_W'(block_count_b);
    count_a_eff = (cnt_a_wide > CMP_W'(dpfl_pkg::POOL_DEPTH)) ?
                  LVL_W'(dpfl_pkg::POOL_DEPTH) : LVL_W'(cnt_a_wide);
    count_b_eff = (cnt_b_wide > CMP_W'(dpfl_pkg::POOL_DEPTH)) ?
                  LVL_W'(dpfl_pkg::POOL_DEPTH) : LVL_W'(cnt_b_wide);
  end

  // Pool bounds, refreshed every cycle: spans, start of pool one, end of pool one.
  logic [SPAN_W-1:0]  span_a, span_b;
  logic [START_W-1:0] start1;
  logic [END_W-1:0]   end1;

  always_ff @(posedge clk) begin
    span_a <= SPAN_W'(size_a_eff) * SPAN_W'(count_a_eff);
    span_b <= SPAN_W'(size_b_eff) * SPAN_W'(count_b_eff);
    start1 <= START_W'(base_address) + START_W'(span_a);
    end1   <= END_W'(start1) + END_W'(span_b);
  end

  // Captured input word.
  logic [1:0]        item_action;
  logic              item_pool;
  logic [ADDR_W-1:0] item_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action <= in_action;
      item_pool   <= in_pool;
      item_addr   <= in_address;
    end
  end

  // Pool selection and bound checks.
  logic [END_W-1:0]   addr_w;
  logic               lt_base, lt_start1, lt_end1, null_addr, act_pool;
  logic [START_W-1:0] start_p;
  logic [SIZE_W-1:0]  size_p;
  logic [LVL_W-1:0]   count_p;
  logic [LVL_W-1:0]   lvl_a, lvl_b, lvl_p;

  always_comb begin
    addr_w    = END_W'(item_addr);
    lt_base   = addr_w < END_W'(base_address);
    lt_start1 = addr_w < END_W'(start1);
    lt_end1   = addr_w < end1;
    null_addr = (item_addr == '0);
    if (item_action == dpfl_pkg::OP_FREE) begin
      act_pool = null_addr ? 1'b0 : !lt_start1;
    end else begin
      act_pool = item_pool;
    end
    start_p = act_pool ? start1 : START_W'(base_address);
    size_p  = act_pool ? size_b_eff : size_a_eff;
    count_p = act_pool ? count_b_eff : count_a_eff;
    lvl_p   = act_pool ? lvl_b : lvl_a;
  end

  // Restoring divider: one quotient bit per cycle, offset divided by block size.
  logic [SPAN_W-1:0] rem;
  logic [SH_W-1:0]   sh;
  logic [IDX_W-1:0]  quo;
  logic [DCNT_W-1:0] dcnt;
  logic              ge;

  assign ge = rem >= SPAN_W'(sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= DCNT_W'(IDX_W);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= SPAN_W'(START_W'(item_addr) - start_p);
      sh  <= SH_W'(size_p) << (IDX_W - 1);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - SPAN_W'(sh);
      end
      quo <= IDX_W'({quo, ge});
      sh  <= sh >> 1;
    end
  end

  // Refill sweep counter.
  logic [LVL_W-1:0] clr_k;

  always_ff @(posedge clk) begin
    if (cmd.clr_start) begin
      clr_k <= '0;
    end else if (cmd.clr_step) begin
      clr_k <= clr_k + LVL_W'(1);
    end
  end

  // Free stacks: one write port and one registered read port each.
  logic [IDX_W-1:0] stack_a [dpfl_pkg::POOL_DEPTH];
  logic [IDX_W-1:0] stack_b [dpfl_pkg::POOL_DEPTH];
  logic [IDX_W-1:0] wr_addr, wr_data, rd_addr;
  logic [IDX_W-1:0] rd_a, rd_b, rd_p;
  logic             wr_en;

  always_comb begin
    wr_en   = cmd.push || cmd.clr_step;
    wr_addr = cmd.push ? lvl_p[IDX_W-1:0] : clr_k[IDX_W-1:0];
    wr_data = cmd.push ? quo : IDX_W'(count_p - LVL_W'(1) - clr_k);
    rd_addr = IDX_W'(lvl_p - LVL_W'(1));
    rd_p    = item_pool ? rd_b : rd_a;
  end

  always_ff @(posedge clk) begin
    if (wr_en && !act_pool) begin
      stack_a[wr_addr] <= wr_data;
    end
    if (cmd.pop && !act_pool) begin
      rd_a <= stack_a[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && act_pool) begin
      stack_b[wr_addr] <= wr_data;
    end
    if (cmd.pop && act_pool) begin
      rd_b <= stack_b[rd_addr];
    end
  end

  // Stack levels.
  logic [LVL_W-1:0] lvl_p_next;

  always_comb begin
    lvl_p_next = lvl_p;
    if (cmd.pop) begin
      lvl_p_next = lvl_p - LVL_W'(1);
    end else if (cmd.push) begin
      lvl_p_next = lvl_p + LVL_W'(1);
    end else if (cmd.clr_finish) begin
      lvl_p_next = count_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_a <= '0;
      lvl_b <= '0;
    end else if (act_pool) begin
      lvl_b <= lvl_p_next;
    end else begin
      lvl_a <= lvl_p_next;
    end
  end

  // Allocation address: index times block size, then offset by the pool start.
  logic [SH_W-1:0]   prod;
  logic [ADDR_W-1:0] alloc_sum;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= SH_W'(rd_p) * SH_W'(size_p);
    end
  end

  assign alloc_sum = ADDR_W'(start_p) + ADDR_W'(prod);

  // Result register.
  logic [ADDR_W-1:0] res_addr;
  logic              res_pool;
  logic [2:0]        res_status;

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_addr   <= cmd.use_alloc_addr ? alloc_sum : '0;
      res_pool   <= act_pool;
      res_status <= cmd.res_status;
    end
  end

  assign block_address = res_addr;
  assign which_pool    = res_pool;
  assign status        = res_status;
  assign free_blocks   = dpfl_pkg::free_field(res_pool ? lvl_b : lvl_a);

  always_comb begin
    stat.action       = item_action;
    stat.null_addr    = null_addr;
    stat.out_of_range = act_pool ? !lt_end1 : lt_base;
    stat.full         = lvl_p >= count_p;
    stat.empty        = (lvl_p == '0);
    stat.div_done     = (dcnt == '0);
    stat.clr_done     = (clr_k == count_p);
  end

endmodule

// File: sv/dpfl_chk.sv
// Port-level checker for the allocator, bound to the top level.
module dpfl_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [dpfl_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input logic [dpfl_pkg::OUT_TUSER_W-1:0]     m_tuser
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only one word is in flight: no acceptance while a result is shown.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // A result never appears in the cycle right after an acceptance.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid)
    else $error("result appeared too early");

  // Only a successful allocate carries a block address.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[3:1] != dpfl_pkg::ST_OK) |-> m_tdata[31:0] == '0)
    else $error("non-zero block address on a failed operation");

  // An empty pool reports no free blocks.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[3:1] == dpfl_pkg::ST_EMPTY) |-> m_tdata[42:32] == '0)
    else $error("empty status with non-zero free count");

endmodule

bind dual_pool_free_list_allocator_top dpfl_chk u_dpfl_chk (.*);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dual-pool free-list block allocator.
module tb_top;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT = 10000;
  localparam int         HOLD_LONG  = 400;

  typedef struct packed {
    logic [dpfl_pkg::ADDR_W-1:0] block_address;
    logic                        which_pool;
    logic [2:0]                  status;
    logic [dpfl_pkg::FREE_W-1:0] free_blocks;
  } outcome_t;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [dpfl_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic [dpfl_pkg::IN_TUSER_W-1:0]  s_tuser;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [dpfl_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [dpfl_pkg::OUT_TUSER_W-1:0] m_tuser;
  logic                             cfg_we;
  logic [dpfl_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [dpfl_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Mirror of the allocator: settings, both free stacks and their levels.
  logic [dpfl_pkg::ADDR_W-1:0]  cfg_base;
  logic [dpfl_pkg::SIZE_W-1:0]  cfg_size [2];
  logic [dpfl_pkg::COUNT_W-1:0] cfg_count [2];
  logic [dpfl_pkg::IDX_W-1:0]   free_idx [2][dpfl_pkg::POOL_DEPTH];
  logic [dpfl_pkg::LVL_W-1:0]   level [2];

  outcome_t                    outstanding_results [$];
  logic [dpfl_pkg::ADDR_W-1:0] held_blocks [$];

  int          mismatches = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          settings_applied = 0;
  int          status_seen [8];
  bit          calm = 1'b0;
  int unsigned hold_request = 0;
  int          idle_cycles = 0;

  dual_pool_free_list_allocator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] unit_bytes(input logic p);
    return (cfg_size[p] == '0) ? 64'd1 : 64'(cfg_size[p]);
  endfunction

  function automatic logic [dpfl_pkg::COUNT_W-1:0] usable_blocks(input logic p);
    return (cfg_count[p] > dpfl_pkg::POOL_DEPTH) ?
           dpfl_pkg::COUNT_W'(dpfl_pkg::POOL_DEPTH) : cfg_count[p];
  endfunction

  function automatic logic [63:0] region_start(input logic p);
    logic [63:0] s;
    s = 64'(cfg_base);
    if (p) s = s + unit_bytes(1'b0) * usable_blocks(1'b0);
    return s;
  endfunction

  // Applies one word to the mirror and returns the result it must produce.
  function automatic outcome_t pool_op_result(input logic [1:0] act, input logic pool,
                                              input logic [dpfl_pkg::ADDR_W-1:0] addr);
    outcome_t                     o;
    logic                         p;
    logic [63:0]                  lo;
    logic [63:0]                  sz;
    logic [dpfl_pkg::COUNT_W-1:0] cnt;
    o = '0;
    p = pool;
    case (act)
      dpfl_pkg::OP_FREE: begin
        if (addr == '0) begin
          o.status = dpfl_pkg::ST_NULL;
          p = 1'b0;
        end else begin
          p = (64'(addr) < region_start(1'b1)) ? 1'b0 : 1'b1;
          lo = region_start(p);
          sz = unit_bytes(p);
          cnt = usable_blocks(p);
          if (64'(addr) < lo || 64'(addr) >= lo + sz * cnt) begin
            o.status = dpfl_pkg::ST_RANGE;
          end else if (level[p] >= cnt) begin
            o.status = dpfl_pkg::ST_FULL;
          end else begin
            free_idx[p][level[p][dpfl_pkg::IDX_W-1:0]] =
              dpfl_pkg::IDX_W'((64'(addr) - lo) / sz);
            level[p] = level[p] + 1'b1;
          end
        end
      end
      dpfl_pkg::OP_ALLOC: begin
        if (level[p] == '0) begin
          o.status = dpfl_pkg::ST_EMPTY;
        end else begin
          level[p] = level[p] - 1'b1;
          o.block_address = dpfl_pkg::ADDR_W'(region_start(p) +
            free_idx[p][level[p][dpfl_pkg::IDX_W-1:0]] * unit_bytes(p));
        end
      end
      dpfl_pkg::OP_CLEAR: begin
        cnt = usable_blocks(p);
        for (int k = 0; k < cnt; k++) free_idx[p][k] = dpfl_pkg::IDX_W'(cnt - 1 - k);
        level[p] = dpfl_pkg::LVL_W'(cnt);
      end
      default: ;
    endcase
    o.which_pool = p;
    o.free_blocks = dpfl_pkg::FREE_W'(level[p]);
    return o;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Called at a falling edge; returns at a falling edge with the word taken.
  task automatic send_word(input logic [1:0] act, input logic pool,
                           input logic [dpfl_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    outcome_t    o;
    gap = calm ? 0 : gap_cycles();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= {pool, act};
    do @(posedge clk); while (!s_tready);
    o = pool_op_result(act, pool, addr);
    outstanding_results.push_back(o);
    words_sent++;
    status_seen[o.status]++;
    if (act == dpfl_pkg::OP_ALLOC && o.status == dpfl_pkg::ST_OK) begin
      held_blocks.push_back(o.block_address);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding_results.size() != 0);
  endtask

  task automatic write_reg(input logic [dpfl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpfl_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      dpfl_pkg::CFG_BASE_ADDRESS:  cfg_base = data;
      dpfl_pkg::CFG_BLOCK_SIZE_A:  cfg_size[0] = data[dpfl_pkg::SIZE_W-1:0];
      dpfl_pkg::CFG_BLOCK_COUNT_A: cfg_count[0] = data[dpfl_pkg::COUNT_W-1:0];
      dpfl_pkg::CFG_BLOCK_SIZE_B:  cfg_size[1] = data[dpfl_pkg::SIZE_W-1:0];
      dpfl_pkg::CFG_BLOCK_COUNT_B: cfg_count[1] = data[dpfl_pkg::COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [dpfl_pkg::ADDR_W-1:0]  base,
                                input logic [dpfl_pkg::SIZE_W-1:0]  size_a,
                                input logic [dpfl_pkg::COUNT_W-1:0] count_a,
                                input logic [dpfl_pkg::SIZE_W-1:0]  size_b,
                                input logic [dpfl_pkg::COUNT_W-1:0] count_b);
    settle();
    write_reg(dpfl_pkg::CFG_BASE_ADDRESS, base);
    write_reg(dpfl_pkg::CFG_BLOCK_SIZE_A, dpfl_pkg::CFG_DATA_W'(size_a));
    write_reg(dpfl_pkg::CFG_BLOCK_COUNT_A, dpfl_pkg::CFG_DATA_W'(count_a));
    write_reg(dpfl_pkg::CFG_BLOCK_SIZE_B, dpfl_pkg::CFG_DATA_W'(size_b));
    write_reg(dpfl_pkg::CFG_BLOCK_COUNT_B, dpfl_pkg::CFG_DATA_W'(count_b));
    cfg_we <= 1'b0;
    held_blocks.delete();
    settings_applied++;
  endtask

  // Allocate, free, clear and unused-action traffic, frees mostly of blocks handed out earlier.
  task automatic run_mix(input int n);
    int unsigned                 r;
    int                          pick;
    logic                        p;
    logic [dpfl_pkg::ADDR_W-1:0] a;
    logic [63:0]                 span;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      p = 1'($urandom_range(0, 1));
      a = $urandom();
      if (r < 4) begin
        send_word(dpfl_pkg::OP_CLEAR, p, a);
      end else if (r < 38) begin
        send_word(dpfl_pkg::OP_ALLOC, p, a);
      end else if (r < 72 && held_blocks.size() != 0) begin
        pick = $urandom_range(0, held_blocks.size() - 1);
        a = held_blocks[pick];
        held_blocks.delete(pick);
        // A free anywhere inside the block still returns the same index.
        if ($urandom_range(0, 3) == 0) begin
          p = (64'(a) >= region_start(1'b1));
          a = a + dpfl_pkg::ADDR_W'($urandom_range(0, 32'(unit_bytes(p)) - 1));
        end
        send_word(dpfl_pkg::OP_FREE, p, a);
      end else if (r < 84) begin
        span = unit_bytes(p) * usable_blocks(p);
        a = dpfl_pkg::ADDR_W'(region_start(p) + 64'($urandom_range(0, 32'(span) + 8))
                              - 64'd4);
        send_word(dpfl_pkg::OP_FREE, p, a);
      end else if (r < 88) begin
        send_word(dpfl_pkg::OP_FREE, p, '0);
      end else if (r < 92) begin
        send_word(OP_UNUSED, p, a);
      end else begin
        send_word(dpfl_pkg::OP_FREE, p, a);
      end
      if ($urandom_range(0, 49) == 0) settle();
    end
  endtask

  task automatic clear_both();
    send_word(dpfl_pkg::OP_CLEAR, 1'b0, '0);
    send_word(dpfl_pkg::OP_CLEAR, 1'b1, '0);
  endtask

  task automatic test_directed();
    logic [dpfl_pkg::ADDR_W-1:0] base;
    logic [dpfl_pkg::ADDR_W-1:0] start_b;
    // Settings left by reset: an empty pool, then one block freed and handed back.
    send_word(dpfl_pkg::OP_ALLOC, 1'b0, '0);
    send_word(dpfl_pkg::OP_FREE, 1'b0, 32'd4096);
    send_word(dpfl_pkg::OP_ALLOC, 1'b0, '0);
    // Pool zero with a zero block size (one byte) and three blocks, pool one with two.
    base = 32'h8000_0000;
    start_b = base + 32'd3;
    apply_settings(base, '0, 11'd3, 13'd4096, 11'd2);
    send_word(dpfl_pkg::OP_ALLOC, 1'b0, '0);
    send_word(dpfl_pkg::OP_ALLOC, 1'b1, '0);
    send_word(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
    send_word(dpfl_pkg::OP_FREE, 1'b1, '0);
    clear_both();
    repeat (4) send_word(dpfl_pkg::OP_ALLOC, 1'b0, '0);
    send_word(dpfl_pkg::OP_FREE, 1'b0, base + 32'd1);
    send_word(dpfl_pkg::OP_FREE, 1'b0, base - 32'd1);
    send_word(dpfl_pkg::OP_FREE, 1'b0, start_b + 32'd8192);
    send_word(dpfl_pkg::OP_FREE, 1'b0, start_b + 32'd5);
    send_word(dpfl_pkg::OP_ALLOC, 1'b1, '0);
    send_word(dpfl_pkg::OP_ALLOC, 1'b1, '0);
    send_word(dpfl_pkg::OP_FREE, 1'b0, start_b + 32'd4196);
    send_word(dpfl_pkg::OP_FREE, 1'b1, start_b + 32'd4095);
    send_word(dpfl_pkg::OP_FREE, 1'b0, 32'hFFFF_FFFF);
    send_word(dpfl_pkg::OP_FREE, 1'b1, 32'h0000_0001);
    send_word(dpfl_pkg::OP_ALLOC, 1'b1, '0);
    send_word(OP_UNUSED, 1'b0, '0);
    send_word(dpfl_pkg::OP_ALLOC, 1'b0, '0);
  endtask

  task automatic test_extreme_settings();
    // Top of the address space with the largest pool-zero size and count: allocations wrap.
    apply_settings(32'hFFFF_FFFF, 13'h1FFF, 11'h7FF, 13'd1, 11'd0);
    clear_both();
    run_mix(40);
    apply_settings(32'd0, 13'd4096, 11'd1024, 13'd4096, 11'd1024);
    clear_both();
    run_mix(40);
    apply_settings(32'd1, 13'd1, 11'd1, 13'd0, 11'd1);
    clear_both();
    run_mix(40);
  endtask

  task automatic test_random_traffic();
    logic [dpfl_pkg::ADDR_W-1:0]  base;
    logic [dpfl_pkg::SIZE_W-1:0]  sz [2];
    logic [dpfl_pkg::COUNT_W-1:0] cnt [2];
    int unsigned                  r;
    for (int ph = 0; ph < 20; ph++) begin
      r = $urandom_range(0, 9);
      base = (r < 6) ? $urandom() :
             (r < 8) ? dpfl_pkg::ADDR_W'($urandom_range(1, 4096)) :
                       dpfl_pkg::ADDR_W'(32'hFFFF_F000 + $urandom_range(0, 4095));
      for (int p = 0; p < 2; p++) begin
        r = $urandom_range(0, 19);
        sz[p] = (r < 2) ? '0 :
                (r < 4) ? dpfl_pkg::SIZE_W'($urandom_range(4096, 8191)) :
                          dpfl_pkg::SIZE_W'($urandom_range(1, 256));
        r = $urandom_range(0, 19);
        // Mostly small pools, so that clears stay short.
        cnt[p] = (r < 2) ? '0 :
                 (r < 3) ? dpfl_pkg::COUNT_W'($urandom_range(1024, 2047)) :
                           dpfl_pkg::COUNT_W'($urandom_range(1, 48));
      end
      apply_settings(base, sz[0], cnt[0], sz[1], cnt[1]);
      calm = (ph % 4 == 3);
      clear_both();
      run_mix(43);
      calm = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    apply_settings(32'h0001_0000, 13'd32, 11'd16, 13'd48, 11'd16);
    clear_both();
    settle();
    calm = 1'b1;
    hold_request = HOLD_LONG;
    run_mix(15);
    calm = 1'b0;
    settle();
  endtask

  // Result sink: random stalls, plus a long hold when one is asked for.
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!calm) stall_left = gap_cycles();
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t got;
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.block_address = m_tdata[31:0];
      got.free_blocks   = m_tdata[42:32];
      got.which_pool    = m_tuser[0];
      got.status        = m_tuser[3:1];
      if (outstanding_results.size() == 0) begin
        $error("result word with nothing outstanding: %h / %h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = outstanding_results.pop_front();
        results_checked++;
        if (got.block_address !== want.block_address) begin
          $error("block_address: expected %h, got %h", want.block_address, got.block_address);
          mismatches++;
        end
        if (got.which_pool !== want.which_pool) begin
          $error("which_pool: expected %0d, got %0d", want.which_pool, got.which_pool);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.free_blocks !== want.free_blocks) begin
          $error("free_blocks: expected %0d, got %0d", want.free_blocks, got.free_blocks);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               idle_cycles, outstanding_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_base = 32'd4096;
    cfg_size[0] = 13'd64;
    cfg_size[1] = 13'd64;
    cfg_count[0] = 11'd1024;
    cfg_count[1] = 11'd1024;
    level[0] = '0;
    level[1] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_extreme_settings();
    test_random_traffic();
    test_backpressure();

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d words under %0d settings, checked %0d results.",
             words_sent, settings_applied + 1, results_checked);
    $display("Status mix: ok %0d, empty %0d, full %0d, null %0d, out of range %0d.",
             status_seen[dpfl_pkg::ST_OK], status_seen[dpfl_pkg::ST_EMPTY],
             status_seen[dpfl_pkg::ST_FULL], status_seen[dpfl_pkg::ST_NULL],
             status_seen[dpfl_pkg::ST_RANGE]);
    if (mismatches == 0 && outstanding_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
